FILE: sv/vpc_pkg.sv
// Shared types, constants and latency helpers for the vdW pair combining rule.
// No dependencies; every other file except vpc_delay imports this package.
`timescale 1ns / 1ps

package vpc_pkg;

    localparam int FIELD_W = 24;
    localparam int DEPTH_W = 32;
    localparam int QF      = 24;
    localparam int SAT_W   = 62;
    localparam int FAC_W   = 25;
    localparam int CONST_W = 32;

    localparam logic [SAT_W-1:0]   SATV   = {SAT_W{1'b1}};
    localparam logic [CONST_W-1:0] B_Q24  = 32'd3355443;
    localparam logic [CONST_W-1:0] K_Q24  = 32'd3039360451;

    localparam int MUL_LAT = 3;
    localparam int EXP_LAT = 17;

    typedef struct packed {
        logic [FIELD_W-1:0] polarizability_first;
        logic [FIELD_W-1:0] electrons_first;
        logic [FIELD_W-1:0] scale_first;
        logic [FIELD_W-1:0] depth_factor_first;
        logic [FIELD_W-1:0] polarizability_second;
        logic [FIELD_W-1:0] electrons_second;
        logic [FIELD_W-1:0] scale_second;
        logic [FIELD_W-1:0] depth_factor_second;
    } item_t;

    typedef struct packed {
        logic [FIELD_W-1:0] pair_radius;
        logic [DEPTH_W-1:0] pair_well_depth;
    } result_t;

    // root width of floor(sqrt(v * 2^24)) for a v of iw bits
    function automatic int sqrt_root_bits(input int iw);
        return (iw + QF + (iw % 2)) / 2;
    endfunction

    function automatic int div_lat(input int nw);
        return nw + QF + 1;
    endfunction

endpackage

FILE: sv/vpc_delay.sv
// Fixed-length delay line that keeps side values aligned with the pipeline.
// Depends on nothing but the clock.
`timescale 1ns / 1ps

module vpc_delay #(
    parameter int W = 8,
    parameter int N = 1
) (
    input  logic         clk,
    input  logic [W-1:0] din,
    output logic [W-1:0] dout
);

    if (N == 0) begin : g_none
        assign dout = din;
    end else begin : g_line
        logic [W-1:0] sr_reg [0:N-1];

        always_ff @(posedge clk)
        begin
            sr_reg[0] <= din;
            for (int i = 1; i < N; i++)
            begin
                sr_reg[i] <= sr_reg[i-1];
            end
        end

        assign dout = sr_reg[N-1];
    end

endmodule

FILE: sv/vpc_mul_sat.sv
// Pipelined saturating product min(floor(a*b / 2^SH), SATV), three stages:
// four half-width partial products, their sum, then shift and clamp. Uses vpc_pkg.
`timescale 1ns / 1ps

module vpc_mul_sat import vpc_pkg::*; #(
    parameter int AW = 32,
    parameter int BW = 32,
    parameter int SH = 24
) (
    input  logic             clk,
    input  logic [AW-1:0]    a,
    input  logic [BW-1:0]    b,
    output logic [SAT_W-1:0] p
);

    localparam int AL = (AW + 1) / 2;
    localparam int AH = AW - AL;
    localparam int BL = (BW + 1) / 2;
    localparam int BH = BW - BL;
    localparam int PW = AW + BW;
    localparam int EW = PW + SAT_W;

    logic [AL+BL-1:0]  ll_reg;
    logic [AL+BH-1:0]  lh_reg;
    logic [AH+BL-1:0]  hl_reg;
    logic [AH+BH-1:0]  hh_reg;
    logic [PW-1:0]     prod_reg;
    logic [PW-1:0]     prod_next;
    logic [EW-1:0]     shifted;
    logic [SAT_W-1:0]  p_reg;
    logic [SAT_W-1:0]  p_next;

    always_comb
    begin
        prod_next = PW'(ll_reg) + (PW'(lh_reg) << BL) + (PW'(hl_reg) << AL)
                  + (PW'(hh_reg) << (AL + BL));
        shifted   = EW'(prod_reg) >> SH;
        p_next    = (shifted > EW'(SATV)) ? SATV : shifted[SAT_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        ll_reg   <= a[AL-1:0] * b[BL-1:0];
        lh_reg   <= a[AL-1:0] * b[BW-1:BL];
        hl_reg   <= a[AW-1:AL] * b[BL-1:0];
        hh_reg   <= a[AW-1:AL] * b[BW-1:BL];
        prod_reg <= prod_next;
        p_reg    <= p_next;
    end

    assign p = p_reg;

endmodule

FILE: sv/vpc_div_sat.sv
// Pipelined restoring divider: min(floor(n * 2^24 / d), SATV), one quotient bit
// per stage plus an output stage; zero dividend gives zero. Uses vpc_pkg.
`timescale 1ns / 1ps

module vpc_div_sat import vpc_pkg::*; #(
    parameter int NW = 32,
    parameter int DW = 32
) (
    input  logic             clk,
    input  logic [NW-1:0]    n,
    input  logic [DW-1:0]    d,
    output logic [SAT_W-1:0] q
);

    localparam int QB = NW + QF;
    localparam int XW = QB + SAT_W;

    logic [DW-1:0] rem_reg [0:QB-1];
    logic [QB-1:0] dv_reg  [0:QB-1];
    logic [QB-1:0] quo_reg [0:QB-1];
    logic [DW-1:0] dsr_reg [0:QB-1];
    logic [1:0]    flg_reg [0:QB-1];   // {dividend zero, divisor zero}

    logic [XW-1:0]    qx;
    logic [SAT_W-1:0] q_reg;
    logic [SAT_W-1:0] q_next;

    for (genvar k = 0; k < QB; k++) begin : g_stage
        logic [DW-1:0] rem_in;
        logic [QB-1:0] dv_in;
        logic [QB-1:0] quo_in;
        logic [DW-1:0] d_in;
        logic [1:0]    flg_in;
        logic [DW:0]   trial;
        logic [DW:0]   diff;
        logic          ge;
        logic [DW-1:0] rem_next;

        if (k == 0) begin : g_first
            assign rem_in = '0;
            assign dv_in  = {n, {QF{1'b0}}};
            assign quo_in = '0;
            assign d_in   = d;
            assign flg_in = {n == '0, d == '0};
        end else begin : g_next
            assign rem_in = rem_reg[k-1];
            assign dv_in  = dv_reg[k-1];
            assign quo_in = quo_reg[k-1];
            assign d_in   = dsr_reg[k-1];
            assign flg_in = flg_reg[k-1];
        end

        always_comb
        begin
            trial    = {rem_in, dv_in[QB-1]};
            diff     = trial - {1'b0, d_in};
            ge       = (trial >= {1'b0, d_in});
            rem_next = ge ? diff[DW-1:0] : trial[DW-1:0];
        end

        always_ff @(posedge clk)
        begin
            rem_reg[k] <= rem_next;
            dv_reg[k]  <= dv_in << 1;
            quo_reg[k] <= {quo_in[QB-2:0], ge};
            dsr_reg[k] <= d_in;
            flg_reg[k] <= flg_in;
        end
    end

    always_comb
    begin
        qx = XW'(quo_reg[QB-1]);
        if (flg_reg[QB-1][1])
            q_next = '0;
        else if (flg_reg[QB-1][0] || (qx > XW'(SATV)))
            q_next = SATV;
        else
            q_next = qx[SAT_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

    assign q = q_reg;

endmodule

FILE: sv/vpc_sqrt.sv
// Pipelined digit-by-digit square root floor(sqrt(v * 2^24)), one root bit
// per stage. Uses vpc_pkg for the width helper.
`timescale 1ns / 1ps

module vpc_sqrt import vpc_pkg::*; #(
    parameter int IW = 32
) (
    input  logic                         clk,
    input  logic [IW-1:0]                v,
    output logic [sqrt_root_bits(IW)-1:0] root
);

    localparam int RB = sqrt_root_bits(IW);
    localparam int XW = 2 * RB;

    logic [RB:0]   rem_reg [0:RB-1];
    logic [XW-1:0] x_reg   [0:RB-1];
    logic [RB-1:0] rt_reg  [0:RB-1];

    for (genvar k = 0; k < RB; k++) begin : g_stage
        logic [RB:0]   rem_in;
        logic [XW-1:0] x_in;
        logic [RB-1:0] rt_in;
        logic [RB+2:0] t;
        logic [RB+2:0] trial;
        logic [RB+2:0] diff;
        logic          ge;
        logic [RB:0]   rem_next;

        if (k == 0) begin : g_first
            assign rem_in = '0;
            assign x_in   = XW'(v) << QF;
            assign rt_in  = '0;
        end else begin : g_next
            assign rem_in = rem_reg[k-1];
            assign x_in   = x_reg[k-1];
            assign rt_in  = rt_reg[k-1];
        end

        always_comb
        begin
            t        = {rem_in, x_in[XW-1:XW-2]};
            trial    = (RB+3)'({rt_in, 2'b01});
            diff     = t - trial;
            ge       = (t >= trial);
            rem_next = ge ? diff[RB:0] : t[RB:0];
        end

        always_ff @(posedge clk)
        begin
            rem_reg[k] <= rem_next;
            x_reg[k]   <= x_in << 2;
            rt_reg[k]  <= {rt_in[RB-2:0], ge};
        end
    end

    assign root = rt_reg[RB-1];

endmodule

FILE: sv/vpc_exp_fac.sv
// Asymmetry factor 1 + 0.2*(1 - exp(-12*gamma^2)) in Q.24, seventeen stages:
// gamma^2, Taylor terms of exp(-x/256) in Q.30, eight squarings, final scale.
// Uses vpc_pkg.
`timescale 1ns / 1ps

module vpc_exp_fac import vpc_pkg::*; (
    input  logic             clk,
    input  logic [SAT_W-1:0] gam,
    output logic [FAC_W-1:0] fac
);

    localparam int GW = QF + 1;
    localparam int TW = 26;
    localparam int T2W = 22;
    localparam int T3W = 18;
    localparam int T4W = 14;
    localparam int EW = 31;
    localparam logic [GW-1:0] ONE24 = GW'(1) << QF;
    localparam logic [EW-1:0] ONE30 = EW'(1) << 30;
    localparam logic [17:0]   RECIP6  = 18'd174763;  // ceil(2^20 / 6)
    localparam logic [15:0]   RECIP24 = 16'd43691;   // ceil(2^20 / 24)

    logic [GW-1:0]  gc;
    logic [2*GW-1:0] gsq;
    logic [GW-1:0]  g2q_reg;
    logic [TW-1:0]  t_reg [0:4];
    logic [T2W-1:0] t2_reg [0:3];
    logic [T3W-1:0] t3_reg;
    logic [T4W-1:0] t4_reg;
    logic [T3W-1:0] q6_reg [0:1];
    logic [T4W-1:0] q24_reg;
    logic [EW-1:0]  e_reg [0:8];
    logic [GW-1:0]  om_reg;
    logic [FAC_W-1:0] fac_reg;

    logic [2*TW-1:0]          tt;
    logic [T2W+TW-1:0]        t2t;
    logic [T3W+TW-1:0]        t3t;
    logic [T3W+17:0]          t3r;
    logic [T4W+15:0]          t4r;
    logic [EW+1:0]            e_next;
    logic [CONST_W+GW-1:0]    bom;

    always_comb
    begin
        gc  = (gam > SAT_W'(ONE24)) ? ONE24 : gam[GW-1:0];
        gsq = gc * gc;
        tt  = t_reg[0] * t_reg[0];
        t2t = t2_reg[0] * t_reg[1];
        t3t = t3_reg * t_reg[2];
        t3r = t3_reg * RECIP6;
        t4r = t4_reg * RECIP24;
        e_next = (EW+2)'(ONE30) - (EW+2)'(t_reg[4]) + (EW+2)'(t2_reg[3] >> 1)
               + (EW+2)'(q24_reg) - (EW+2)'(q6_reg[1]);
        bom = B_Q24 * om_reg;
    end

    always_ff @(posedge clk)
    begin
        g2q_reg   <= gsq[QF+GW-1:QF];
        t_reg[0]  <= TW'(g2q_reg) * TW'(3);
        t2_reg[0] <= tt[30+T2W-1:30];
        t_reg[1]  <= t_reg[0];
        t3_reg    <= t2t[30+T3W-1:30];
        t2_reg[1] <= t2_reg[0];
        t_reg[2]  <= t_reg[1];
        t4_reg    <= t3t[30+T4W-1:30];
        q6_reg[0] <= T3W'(t3r >> 20);
        t2_reg[2] <= t2_reg[1];
        t_reg[3]  <= t_reg[2];
        q24_reg   <= T4W'(t4r >> 20);
        q6_reg[1] <= q6_reg[0];
        t2_reg[3] <= t2_reg[2];
        t_reg[4]  <= t_reg[3];
        e_reg[0]  <= e_next[EW-1:0];
        om_reg    <= ONE24 - GW'(e_reg[8] >> 6);
        fac_reg   <= FAC_W'(ONE24) + FAC_W'(bom >> QF);
    end

    // eight squarings in Q.30
    for (genvar k = 1; k < 9; k++) begin : g_sq
        logic [2*EW-1:0] esq;

        assign esq = e_reg[k-1] * e_reg[k-1];

        always_ff @(posedge clk)
        begin
            e_reg[k] <= esq[30+EW-1:30];
        end
    end

    assign fac = fac_reg;

endmodule

FILE: sv/vdw_pair_combining_rule.sv
// Top level of the van der Waals pair combining rule pipeline.
// Depends on vpc_pkg, vpc_delay, vpc_mul_sat, vpc_div_sat, vpc_sqrt, vpc_exp_fac.
`timescale 1ns / 1ps

// Channel   Ports               Beat taken when          Width
// input     start, busy, item   start && !busy           8 x 24 bits
// result    done, result        done (one cycle only)     24 + 32 bits
//
// One beat enters every cycle; busy stays low because nothing can back up.
// The three pipelined dividers in series on the depth path set how long each
// beat takes to reach its result. Results leave in input order, one done pulse
// per beat. Reset clears only the valid line; payload stages carry no reset.
// The receiver cannot stall, so the pipeline never holds.

module vdw_pair_combining_rule import vpc_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    output logic    busy,
    input  item_t   item,
    output logic    done,
    output result_t result
);

    // internal widths follow the input scaling
    localparam int SHIN = QF - FRAC_BITS;
    localparam int QW   = 2 * QF - FRAC_BITS;
    localparam int R1   = sqrt_root_bits(QW);
    localparam int R2   = sqrt_root_bits(R1);
    localparam int RW   = QW + R2 - QF;
    localparam int SW   = RW + 1;
    localparam int DIW  = 40;
    localparam int DRW  = sqrt_root_bits(DIW);
    localparam int DNW  = DRW + 1;

    // schedule: cycle at which each value sits in its register
    localparam int T_S2  = R1 + R2;
    localparam int T_R   = T_S2 + MUL_LAT;
    localparam int T_SUM = T_R + 1;
    localparam int T_GAM = T_SUM + div_lat(RW);
    localparam int T_FAC = T_GAM + EXP_LAT;
    localparam int T_RV  = T_FAC + MUL_LAT;
    localparam int T_RSQ = T_RV + MUL_LAT;
    localparam int T_R6  = T_RSQ + 2 * MUL_LAT;
    localparam int T_NUM = 4 * MUL_LAT;
    localparam int T_PN  = div_lat(QW);
    localparam int T_DEN = T_PN + DRW + 1;
    localparam int T_NQ  = T_DEN + div_lat(SAT_W);
    localparam int T_D2  = (T_NQ > T_R6) ? T_NQ : T_R6;
    localparam int T_EPS = T_D2 + div_lat(SAT_W);

    localparam logic [SAT_W-1:0] SQ_MAX  = SAT_W'((64'd1 << DIW) - 64'd1);
    localparam logic [SAT_W-1:0] DEP_MAX = SAT_W'({DEPTH_W{1'b1}});

    logic [T_EPS:0] vld_reg;

    logic [QW-1:0] p1_reg, n1_reg, a1_reg, g1_reg;
    logic [QW-1:0] p2_reg, n2_reg, a2_reg, g2_reg;

    logic [R1-1:0]    s1a, s1b;
    logic [R2-1:0]    s2a, s2b;
    logic [QW-1:0]    a1_d, a2_d;
    logic [SAT_W-1:0] r1_full, r2_full;
    logic [RW-1:0]    r1, r2;
    logic [SW-1:0]    sum_reg;
    logic [RW-1:0]    diff_reg;
    logic [SW-1:0]    sum_d;
    logic [SAT_W-1:0] gam;
    logic [FAC_W-1:0] fac;
    logic [SAT_W-1:0] rv_full;
    logic [SW-1:0]    rv;
    logic [SW-1:0]    rv_d;
    logic [SAT_W-1:0] rsq, rsq_d, rq4, rv6, rv6_d;

    logic [QW-1:0]    g2_d, p1_d, p2_d;
    logic [SAT_W-1:0] m0, m1, m2, num, num_d;
    logic [SAT_W-1:0] pn1, pn2;
    logic [DIW-1:0]   pc1, pc2;
    logic [DRW-1:0]   sd1, sd2;
    logic [DNW-1:0]   den_reg;
    logic [SAT_W-1:0] nq, nq_d, eps;

    logic [SW-1:0]      rad_sh;
    logic [FIELD_W-1:0] rad;
    logic [DEPTH_W-1:0] dep;
    result_t            result_reg;
    result_t            result_next;
    logic               done_reg;

    // pipeline never stalls
    assign busy = 1'b0;

    // valid bits ride alongside the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            vld_reg  <= {vld_reg[T_EPS-1:0], start};
            done_reg <= vld_reg[T_EPS];
        end
    end

    // input stage: move every field to Q.24
    always_ff @(posedge clk)
    begin
        p1_reg <= QW'(item.polarizability_first) << SHIN;
        n1_reg <= QW'(item.electrons_first) << SHIN;
        a1_reg <= QW'(item.scale_first) << SHIN;
        g1_reg <= QW'(item.depth_factor_first) << SHIN;
        p2_reg <= QW'(item.polarizability_second) << SHIN;
        n2_reg <= QW'(item.electrons_second) << SHIN;
        a2_reg <= QW'(item.scale_second) << SHIN;
        g2_reg <= QW'(item.depth_factor_second) << SHIN;
    end

    // ---------------- radius path ----------------
    // per-atom radius: scale * fourth root of polarizability
    vpc_sqrt #(.IW(QW)) u_sq1a (.clk(clk), .v(p1_reg), .root(s1a));
    vpc_sqrt #(.IW(QW)) u_sq1b (.clk(clk), .v(p2_reg), .root(s1b));
    vpc_sqrt #(.IW(R1)) u_sq2a (.clk(clk), .v(s1a), .root(s2a));
    vpc_sqrt #(.IW(R1)) u_sq2b (.clk(clk), .v(s1b), .root(s2b));

    vpc_delay #(.W(QW), .N(T_S2)) u_dla1 (.clk(clk), .din(a1_reg), .dout(a1_d));
    vpc_delay #(.W(QW), .N(T_S2)) u_dla2 (.clk(clk), .din(a2_reg), .dout(a2_d));

    vpc_mul_sat #(.AW(QW), .BW(R2), .SH(QF)) u_r1
        (.clk(clk), .a(a1_d), .b(s2a), .p(r1_full));
    vpc_mul_sat #(.AW(QW), .BW(R2), .SH(QF)) u_r2
        (.clk(clk), .a(a2_d), .b(s2b), .p(r2_full));

    assign r1 = r1_full[RW-1:0];
    assign r2 = r2_full[RW-1:0];

    always_ff @(posedge clk)
    begin
        sum_reg  <= SW'(r1) + SW'(r2);
        diff_reg <= (r1 > r2) ? (r1 - r2) : (r2 - r1);
    end

    // gamma = |r1 - r2| / (r1 + r2), then the asymmetry factor
    vpc_div_sat #(.NW(RW), .DW(SW)) u_gam
        (.clk(clk), .n(diff_reg), .d(sum_reg), .q(gam));
    vpc_exp_fac u_fac (.clk(clk), .gam(gam), .fac(fac));

    vpc_delay #(.W(SW), .N(T_FAC - T_SUM)) u_dlsum
        (.clk(clk), .din(sum_reg), .dout(sum_d));

    // half the sum (extra shift bit) times the factor
    vpc_mul_sat #(.AW(SW), .BW(FAC_W), .SH(QF + 1)) u_rv
        (.clk(clk), .a(sum_d), .b(fac), .p(rv_full));
    assign rv = rv_full[SW-1:0];

    // rv^6 as (rv^2)^2 * rv^2
    vpc_mul_sat #(.AW(SW), .BW(SW), .SH(QF)) u_rsq
        (.clk(clk), .a(rv), .b(rv), .p(rsq));
    vpc_mul_sat #(.AW(SAT_W), .BW(SAT_W), .SH(QF)) u_rq4
        (.clk(clk), .a(rsq), .b(rsq), .p(rq4));
    vpc_delay #(.W(SAT_W), .N(MUL_LAT)) u_dlrsq
        (.clk(clk), .din(rsq), .dout(rsq_d));
    vpc_mul_sat #(.AW(SAT_W), .BW(SAT_W), .SH(QF)) u_rv6
        (.clk(clk), .a(rq4), .b(rsq_d), .p(rv6));

    // ---------------- depth path ----------------
    // numerator 181.16 * g1 * g2 * p1 * p2, one product after another
    vpc_delay #(.W(QW), .N(MUL_LAT)) u_dlg2
        (.clk(clk), .din(g2_reg), .dout(g2_d));
    vpc_delay #(.W(QW), .N(2 * MUL_LAT)) u_dlp1
        (.clk(clk), .din(p1_reg), .dout(p1_d));
    vpc_delay #(.W(QW), .N(3 * MUL_LAT)) u_dlp2
        (.clk(clk), .din(p2_reg), .dout(p2_d));

    vpc_mul_sat #(.AW(CONST_W), .BW(QW), .SH(QF)) u_m0
        (.clk(clk), .a(K_Q24), .b(g1_reg), .p(m0));
    vpc_mul_sat #(.AW(SAT_W), .BW(QW), .SH(QF)) u_m1
        (.clk(clk), .a(m0), .b(g2_d), .p(m1));
    vpc_mul_sat #(.AW(SAT_W), .BW(QW), .SH(QF)) u_m2
        (.clk(clk), .a(m1), .b(p1_d), .p(m2));
    vpc_mul_sat #(.AW(SAT_W), .BW(QW), .SH(QF)) u_m3
        (.clk(clk), .a(m2), .b(p2_d), .p(num));

    // denominator sqrt(p1/n1) + sqrt(p2/n2)
    vpc_div_sat #(.NW(QW), .DW(QW)) u_pn1 (.clk(clk), .n(p1_reg), .d(n1_reg), .q(pn1));
    vpc_div_sat #(.NW(QW), .DW(QW)) u_pn2 (.clk(clk), .n(p2_reg), .d(n2_reg), .q(pn2));

    // clamp the root operand to 40 bits
    assign pc1 = (pn1 > SQ_MAX) ? SQ_MAX[DIW-1:0] : pn1[DIW-1:0];
    assign pc2 = (pn2 > SQ_MAX) ? SQ_MAX[DIW-1:0] : pn2[DIW-1:0];

    vpc_sqrt #(.IW(DIW)) u_sqd1 (.clk(clk), .v(pc1), .root(sd1));
    vpc_sqrt #(.IW(DIW)) u_sqd2 (.clk(clk), .v(pc2), .root(sd2));

    always_ff @(posedge clk)
    begin
        den_reg <= DNW'(sd1) + DNW'(sd2);
    end

    vpc_delay #(.W(SAT_W), .N(T_DEN - T_NUM)) u_dlnum
        (.clk(clk), .din(num), .dout(num_d));

    vpc_div_sat #(.NW(SAT_W), .DW(DNW)) u_nq
        (.clk(clk), .n(num_d), .d(den_reg), .q(nq));

    // meet rv^6 and the first quotient, then the second divide
    vpc_delay #(.W(SAT_W), .N(T_D2 - T_NQ)) u_dlnq
        (.clk(clk), .din(nq), .dout(nq_d));
    vpc_delay #(.W(SAT_W), .N(T_D2 - T_R6)) u_dlrv6
        (.clk(clk), .din(rv6), .dout(rv6_d));

    vpc_div_sat #(.NW(SAT_W), .DW(SAT_W)) u_eps
        (.clk(clk), .n(nq_d), .d(rv6_d), .q(eps));

    // hold the radius until the depth catches up
    vpc_delay #(.W(SW), .N(T_EPS - T_RV)) u_dlrv
        (.clk(clk), .din(rv), .dout(rv_d));

    // ---------------- output stage ----------------
    always_comb
    begin
        rad_sh = rv_d >> SHIN;
        rad    = (rad_sh > SW'({FIELD_W{1'b1}})) ? {FIELD_W{1'b1}} : rad_sh[FIELD_W-1:0];
    end

    if (FRAC_BITS >= 16) begin : g_dep_up
        localparam int SHD = FRAC_BITS - 16;
        logic [SAT_W-1:0] eps_sh;

        always_comb
        begin
            eps_sh = eps << SHD;
            dep    = (eps > (DEP_MAX >> SHD)) ? {DEPTH_W{1'b1}} : eps_sh[DEPTH_W-1:0];
        end
    end else begin : g_dep_down
        localparam int SHD = 16 - FRAC_BITS;
        logic [SAT_W-1:0] eps_sh;

        always_comb
        begin
            eps_sh = eps >> SHD;
            dep    = (eps_sh > DEP_MAX) ? {DEPTH_W{1'b1}} : eps_sh[DEPTH_W-1:0];
        end
    end

    always_comb
    begin
        result_next.pair_radius     = rad;
        result_next.pair_well_depth = dep;
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

FILE: bench/tb_vdw_pair_combining_rule.sv
// Self-checking bench for vdw_pair_combining_rule: drives parameter pairs, predicts
// radius and well depth in fixed point, and checks every done beat in order.
// Depends on vpc_pkg and the vdw_pair_combining_rule RTL.
`timescale 1ns / 1ps

module tb_vdw_pair_combining_rule;
    import vpc_pkg::*;

    localparam int FRAC = 16;
    localparam int LATENCY = 265;
    localparam logic [63:0] SAT64 = 64'h3FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] ONE_Q24 = 64'd1 << 24;
    localparam logic [63:0] ONE_Q30 = 64'd1 << 30;

    logic    clk;
    logic    rst_n;
    logic    start;
    logic    busy;
    item_t   item;
    logic    done;
    result_t result;

    int      errors;
    result_t pending_results[$];

    vdw_pair_combining_rule #(.FRAC_BITS(FRAC)) DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .item   (item),
        .done   (done),
        .result (result)
    );

    always #5 clk = ~clk;

    // Ends a hung run.
    initial
    begin
        #5_000_000;
        $display("tb_vdw_pair_combining_rule: FAIL");
        $finish;
    end

    // ---------------------------------------------------------------
    // Fixed-point predictor, internal values in Q.24 (Q.30 inside exp_neg)
    // ---------------------------------------------------------------

    // floor(a*b / 2^s), saturating
    function automatic logic [63:0] q_mul(logic [63:0] a, logic [63:0] b, int s);
        logic [127:0] p;
        p = ({64'd0, a} * {64'd0, b}) >> s;
        return (p > {64'd0, SAT64}) ? SAT64 : p[63:0];
    endfunction

    // floor(n * 2^24 / d), saturating; zero over anything is zero
    function automatic logic [63:0] q_div(logic [63:0] n, logic [63:0] d);
        logic [127:0] q;
        if (n == 0)
            return 64'd0;
        if (d == 0)
            return SAT64;
        if ((n / d) > (SAT64 >> 24))
            return SAT64;
        q = ({64'd0, n} << 24) / {64'd0, d};
        return (q > {64'd0, SAT64}) ? SAT64 : q[63:0];
    endfunction

    function automatic logic [63:0] root64(logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // square root in Q.24, input clamped to 40 bits
    function automatic logic [63:0] q_sqrt(logic [63:0] v);
        if (v > 64'hFF_FFFF_FFFF)
            v = 64'hFF_FFFF_FFFF;
        return root64(v << 24);
    endfunction

    // exp(-x): Taylor series on x/256 in Q.30, then squared eight times
    function automatic logic [63:0] exp_neg(logic [63:0] x);
        logic [63:0] t, t2, t3, t4, e;
        t  = x >> 2;
        t2 = (t * t) >> 30;
        t3 = (t2 * t) >> 30;
        t4 = (t3 * t) >> 30;
        e  = ONE_Q30 - t + (t2 >> 1) + t4 / 24 - t3 / 6;
        for (int i = 0; i < 8; i++)
            e = (e * e) >> 30;
        return e >> 6;
    endfunction

    function automatic result_t predict_pair(item_t it);
        logic [63:0] p1, n1, a1, g1, p2, n2, a2, g2;
        logic [63:0] r1, r2, sum, diff, gam, gsq, fac, rv;
        logic [63:0] num, den, rsq, rv6, eps, rad;
        result_t     res;
        p1 = 64'(it.polarizability_first)  << (24 - FRAC);
        n1 = 64'(it.electrons_first)       << (24 - FRAC);
        a1 = 64'(it.scale_first)           << (24 - FRAC);
        g1 = 64'(it.depth_factor_first)    << (24 - FRAC);
        p2 = 64'(it.polarizability_second) << (24 - FRAC);
        n2 = 64'(it.electrons_second)      << (24 - FRAC);
        a2 = 64'(it.scale_second)          << (24 - FRAC);
        g2 = 64'(it.depth_factor_second)   << (24 - FRAC);

        // per-atom radius from the fourth root of polarizability
        r1   = q_mul(a1, q_sqrt(q_sqrt(p1)), 24);
        r2   = q_mul(a2, q_sqrt(q_sqrt(p2)), 24);
        sum  = r1 + r2;
        diff = (r1 > r2) ? r1 - r2 : r2 - r1;
        gam  = q_div(diff, sum);
        if (gam > ONE_Q24)
            gam = ONE_Q24;
        gsq = (gam * gam) >> 24;
        fac = ONE_Q24 + ((64'(B_Q24) * (ONE_Q24 - exp_neg(12 * gsq))) >> 24);
        // the halving of the radius sum folds into the shift
        rv  = q_mul(sum, fac, 25);

        num = q_mul(64'(K_Q24), g1, 24);
        num = q_mul(num, g2, 24);
        num = q_mul(num, p1, 24);
        num = q_mul(num, p2, 24);
        den = q_sqrt(q_div(p1, n1)) + q_sqrt(q_div(p2, n2));
        rsq = q_mul(rv, rv, 24);
        rv6 = q_mul(q_mul(rsq, rsq, 24), rsq, 24);
        eps = q_div(q_div(num, den), rv6);

        rad = rv >> (24 - FRAC);
        res.pair_radius     = (rad > 64'hFF_FFFF) ? 24'hFF_FFFF : rad[23:0];
        res.pair_well_depth = (eps > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : eps[31:0];
        return res;
    endfunction

    task automatic report_mismatch(string msg);
        errors++;
        $display("mismatch @%0t: %s", $time, msg);
    endtask

    // ---------------------------------------------------------------
    // Monitor: queue a prediction per accepted beat, check each done beat
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
                report_mismatch("result beat with nothing outstanding");
            else
            begin
                want = pending_results.pop_front();
                if (result.pair_radius !== want.pair_radius)
                    report_mismatch($sformatf("pair_radius got %h want %h",
                        result.pair_radius, want.pair_radius));
                if (result.pair_well_depth !== want.pair_well_depth)
                    report_mismatch($sformatf("pair_well_depth got %h want %h",
                        result.pair_well_depth, want.pair_well_depth));
            end
        end
        if (rst_n && start && !busy)
            pending_results.insert(pending_results.size(), predict_pair(item));
    end

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------
    int idle_pct;

    // Hold start high with the beat until busy is seen low, then advance.
    // Idle cycles drop start first; with no idle, start simply stays high.
    task automatic send_beat(item_t it);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        item  <= it;
        @(negedge clk);
        while (busy)
            @(negedge clk);
        @(posedge clk);
    endtask

    // Random field: mostly full range, with a share of tiny, huge and zero values.
    function automatic logic [23:0] rand_field(bit nonzero);
        logic [23:0] v;
        case ($urandom_range(9))
            0:       v = 24'd0;
            1:       v = 24'hFF_FFFF;
            2, 3:    v = 24'($urandom_range(24'h1_FFFF));
            4:       v = 24'($urandom_range(24'h0_0FFF));
            default: v = 24'($urandom);
        endcase
        if (nonzero && v == 0)
            v = 24'd1;
        return v;
    endfunction

    function automatic item_t rand_item();
        item_t it;
        it.polarizability_first  = rand_field(1'b0);
        it.electrons_first       = rand_field(1'b1);
        it.scale_first           = rand_field(1'b0);
        it.depth_factor_first    = rand_field(1'b0);
        it.polarizability_second = rand_field(1'b0);
        it.electrons_second      = rand_field(1'b1);
        it.scale_second          = rand_field(1'b0);
        it.depth_factor_second   = rand_field(1'b0);
        // mirror the first atom now and then: equal radii, gamma zero
        if ($urandom_range(7) == 0)
        begin
            it.polarizability_second = it.polarizability_first;
            it.electrons_second      = it.electrons_first;
            it.scale_second          = it.scale_first;
            it.depth_factor_second   = it.depth_factor_first;
        end
        return it;
    endfunction

    typedef struct {
        item_t   stim;
        bit      typed;
        result_t want;
    } directed_row_t;

    localparam logic [23:0] ONE_Q16 = 24'h01_0000;
    localparam logic [23:0] ALL1 = 24'hFF_FFFF;

    directed_row_t directed_rows[$];
    result_t       zero_result;
    result_t       checked;
    int            wait_cycles;

    // append one row to the stimulus table
    task automatic add_row(directed_row_t row);
        directed_rows.insert(directed_rows.size(), row);
    endtask

    initial
    begin
        clk    = 1'b0;
        rst_n  = 1'b0;
        start  = 1'b0;
        item   = '0;
        errors = 0;
        idle_pct = 0;
        zero_result = '0;

        // Rows: stim fields p1 n1 a1 g1 p2 n2 a2 g2.
        // Both radii zero with zero depth factors: everything is zero.
        add_row('{'{24'd0, 24'd1, 24'd0, 24'd0, 24'd0, 24'd1, 24'd0, 24'd0},
                  1'b1, zero_result});
        // Zero polarizability on both: zero dividend everywhere.
        add_row('{'{24'd0, ALL1, ALL1, ALL1, 24'd0, ALL1, ALL1, ALL1},
                  1'b1, zero_result});
        // Zero scale, nonzero numerator: radii zero, depth over zero saturates.
        add_row('{'{ONE_Q16, ONE_Q16, 24'd0, ONE_Q16,
                    ONE_Q16, ONE_Q16, 24'd0, ONE_Q16},
                  1'b1, '{24'd0, 32'hFFFF_FFFF}});
        // Unit atoms, identical: gamma zero.
        add_row('{'{ONE_Q16, ONE_Q16, ONE_Q16, ONE_Q16,
                    ONE_Q16, ONE_Q16, ONE_Q16, ONE_Q16}, 1'b0, zero_result});
        // All ones: intermediate saturation.
        add_row('{'{ALL1, ALL1, ALL1, ALL1, ALL1, ALL1, ALL1, ALL1},
                  1'b0, zero_result});
        // Minimum electron count, large polarizability.
        add_row('{'{ALL1, 24'd1, ONE_Q16, ONE_Q16, ALL1, 24'd1, ONE_Q16, ONE_Q16},
                  1'b0, zero_result});
        // One radius zero, other not: gamma at one, widest correction.
        add_row('{'{ONE_Q16, ONE_Q16, 24'd0, ONE_Q16,
                    ONE_Q16, ONE_Q16, 24'h02_0000, ONE_Q16}, 1'b0, zero_result});
        add_row('{'{24'h05_0000, 24'h03_0000, 24'h01_8000, 24'h00_4000,
                    24'h0C_0000, 24'h08_0000, 24'h01_4000, 24'h00_8000},
                  1'b0, zero_result});
        // Smallest nonzero values.
        add_row('{'{24'd1, 24'd1, 24'd1, 24'd1, 24'd1, 24'd1, 24'd1, 24'd1},
                  1'b0, zero_result});
        // Alternating bit patterns.
        add_row('{'{24'hAA_AAAA, 24'h55_5555, 24'hAA_AAAA, 24'h55_5555,
                    24'h55_5555, 24'hAA_AAAA, 24'h55_5555, 24'hAA_AAAA},
                  1'b0, zero_result});
        // Large scale, small polarizability: radius saturates.
        add_row('{'{24'h10_0000, ONE_Q16, ALL1, ONE_Q16,
                    24'h10_0000, ONE_Q16, ALL1, ONE_Q16}, 1'b0, zero_result});

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows, back to back; typed rows also cross-check the predictor.
        foreach (directed_rows[i])
        begin
            if (directed_rows[i].typed)
            begin
                checked = predict_pair(directed_rows[i].stim);
                if (checked !== directed_rows[i].want)
                    report_mismatch($sformatf("directed row %0d predicts %h, table has %h",
                        i, checked, directed_rows[i].want));
            end
            send_beat(directed_rows[i].stim);
        end

        // Random beats in three idling phases: light, heavy, none.
        idle_pct = 14;
        repeat (420) send_beat(rand_item());
        idle_pct = 71;
        repeat (420) send_beat(rand_item());
        idle_pct = 0;
        repeat (420) send_beat(rand_item());
        start <= 1'b0;

        // Drain: wait out the pipeline, bounded.
        wait_cycles = 0;
        while (pending_results.size() != 0 && wait_cycles < 4 * LATENCY)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        if (pending_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
        repeat (LATENCY + 20) @(posedge clk);

        if (errors == 0)
            $display("tb_vdw_pair_combining_rule: PASS");
        else
            $display("tb_vdw_pair_combining_rule: FAIL");
        $finish;
    end

endmodule

FILE: vdw_pair_combining_rule.f
sv/vpc_pkg.sv
sv/vpc_delay.sv
sv/vpc_mul_sat.sv
sv/vpc_div_sat.sv
sv/vpc_sqrt.sv
sv/vpc_exp_fac.sv
sv/vdw_pair_combining_rule.sv
bench/tb_vdw_pair_combining_rule.sv
